>>> rtl/islip_pkg.sv
// Shared constants, types and helpers for the iSLIP crossbar scheduler.
package islip_pkg;

    // Crossbar size and derived widths
    localparam int PORTS   = 8;
    localparam int PTR_W   = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int REQ_W   = 64;
    localparam int FIELD_W = 3;

    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [FIELD_W-1:0] port_field_t;

    // One finished round handed to the emitter: accepted outputs and their inputs
    typedef struct packed {
        logic [PORTS-1:0]            mask;
        logic [PORTS-1:0][PTR_W-1:0] by;
    } round_t;

    // Pointer increment modulo PORTS
    function automatic ptr_t wrap_inc(input ptr_t v);
        ptr_t r;
        if (v == ptr_t'(PORTS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = v + ptr_t'(1);
        end
        return r;
    endfunction

endpackage

>>> rtl/islip_if.sv
// Valid/ready channel interfaces for request words and match words.
interface islip_req_if;
    logic                          valid;
    logic                          ready;
    logic [islip_pkg::REQ_W-1:0]   request_matrix;

    modport source (output valid, output request_matrix, input ready);
    modport sink   (input valid, input request_matrix, output ready);
endinterface

interface islip_match_if;
    logic                          valid;
    logic                          ready;
    logic                          match_valid;
    logic [islip_pkg::FIELD_W-1:0] matched_input;
    logic [islip_pkg::FIELD_W-1:0] matched_output;
    logic                          last_match;

    modport source (output valid, output match_valid, output matched_input,
                    output matched_output, output last_match, input ready);
    modport sink   (input valid, input match_valid, input matched_input,
                    input matched_output, input last_match, output ready);
endinterface

>>> rtl/islip_rr_lane.sv
// Round-robin lane: first set request at or after the pointer, wrapping.
module islip_rr_lane (
    input  logic [islip_pkg::PORTS-1:0] req,
    input  islip_pkg::ptr_t             ptr,
    output logic                        found,
    output islip_pkg::ptr_t             idx
);

    logic [islip_pkg::PTR_W:0] sum;
    islip_pkg::ptr_t           cand;

    // Scan from the farthest candidate back so the nearest one wins
    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        sum   = '0;
        cand  = '0;
        for (int k = islip_pkg::PORTS - 1; k >= 0; k--)
        begin
            sum = {1'b0, ptr} + (islip_pkg::PTR_W + 1)'(k);
            if (sum >= (islip_pkg::PTR_W + 1)'(islip_pkg::PORTS))
            begin
                sum = sum - (islip_pkg::PTR_W + 1)'(islip_pkg::PORTS);
            end
            cand = sum[islip_pkg::PTR_W-1:0];
            if (req[cand])
            begin
                found = 1'b1;
                idx   = cand;
            end
        end
    end

endmodule

>>> rtl/islip_emitter.sv
// Output stage: holds one round and sends its pairs in ascending output order.
module islip_emitter (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  islip_pkg::round_t       round_in,
    output logic                    free,
    islip_match_if.source           pairs
);

    logic                                  valid_reg, valid_next;
    logic [islip_pkg::PORTS-1:0]           mask_reg, mask_next;
    logic [islip_pkg::PORTS-1:0][islip_pkg::PTR_W-1:0] by_reg;

    islip_pkg::ptr_t             sel;
    logic                        any;
    logic [islip_pkg::PORTS-1:0] rest;
    logic                        last;
    logic                        fire;

    // Lowest accepted output still pending
    always_comb
    begin
        sel = '0;
        any = 1'b0;
        for (int k = islip_pkg::PORTS - 1; k >= 0; k--)
        begin
            if (mask_reg[k])
            begin
                sel = islip_pkg::ptr_t'(k);
                any = 1'b1;
            end
        end
        rest = mask_reg;
        rest[sel] = 1'b0;
        last = (rest == '0);
    end

    assign fire = valid_reg && pairs.ready;
    assign free = !valid_reg || (fire && last);

    // Output word
    assign pairs.valid          = valid_reg;
    assign pairs.match_valid    = any;
    assign pairs.matched_input  = any ? islip_pkg::port_field_t'(by_reg[sel]) : '0;
    assign pairs.matched_output = any ? islip_pkg::port_field_t'(sel) : '0;
    assign pairs.last_match     = last;

    // Next state
    always_comb
    begin
        valid_next = valid_reg;
        mask_next  = mask_reg;
        if (load)
        begin
            valid_next = 1'b1;
            mask_next  = round_in.mask;
        end
        else if (fire)
        begin
            valid_next = !last;
            mask_next  = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mask_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            mask_reg  <= mask_next;
        end
    end

    // Input indexes, payload only
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            by_reg <= round_in.by;
        end
    end

endmodule

>>> rtl/islip_crossbar_scheduler.sv
// A taken request word is registered in the request buffer; its round is computed from it and
// loaded into the emitter's register once the emitter is free, and the emitter then sends one
// accepted pair per cycle, while the receiver is ready, over the single output channel.
// A request word is buffered while the emitter drains the previous round.
// Reset (rst_n low, async): each grant and accept pointer returns to its own port index,
// buffers empty.
module islip_crossbar_scheduler (
    input  logic           clk,
    input  logic           rst_n,
    islip_req_if.sink      request,
    islip_match_if.source  pairs
);

    localparam int P = islip_pkg::PORTS;

    logic                          req_valid_reg, req_valid_next;
    logic [islip_pkg::REQ_W-1:0]   req_reg;
    islip_pkg::ptr_t [P-1:0]       grant_ptr_reg, grant_ptr_next;
    islip_pkg::ptr_t [P-1:0]       accept_ptr_reg, accept_ptr_next;

    logic [P-1:0][P-1:0]           col;
    logic [P-1:0]                  granted;
    islip_pkg::ptr_t [P-1:0]       grant_to;
    logic [P-1:0][P-1:0]           acc_req;
    logic [P-1:0]                  acc_found;
    islip_pkg::ptr_t [P-1:0]       acc_idx;
    islip_pkg::round_t             round;
    logic                          emit_free;
    logic                          load;

    // Request buffer
    assign load          = req_valid_reg && emit_free;
    assign request.ready = !req_valid_reg || emit_free;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (request.valid && request.ready)
        begin
            req_valid_next = 1'b1;
        end
        else if (load)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            req_reg <= request.request_matrix;
        end
    end

    // Request columns: bit i of col[j] is input i asking for output j
    always_comb
    begin
        for (int j = 0; j < P; j++)
        begin
            for (int i = 0; i < P; i++)
            begin
                col[j][i] = req_reg[i*P + j];
            end
        end
    end

    // Grant lanes, one per output
    for (genvar j = 0; j < P; j++)
    begin : g_grant
        islip_rr_lane u_grant (
            .req   (col[j]),
            .ptr   (grant_ptr_reg[j]),
            .found (granted[j]),
            .idx   (grant_to[j])
        );
    end

    // Grants seen by each input
    always_comb
    begin
        for (int i = 0; i < P; i++)
        begin
            for (int j = 0; j < P; j++)
            begin
                acc_req[i][j] = granted[j] && (grant_to[j] == islip_pkg::ptr_t'(i));
            end
        end
    end

    // Accept lanes, one per input
    for (genvar i = 0; i < P; i++)
    begin : g_accept
        islip_rr_lane u_accept (
            .req   (acc_req[i]),
            .ptr   (accept_ptr_reg[i]),
            .found (acc_found[i]),
            .idx   (acc_idx[i])
        );
    end

    // Merge: an output is matched when its granted input accepted it back
    always_comb
    begin
        for (int j = 0; j < P; j++)
        begin
            round.mask[j] = granted[j] && acc_found[grant_to[j]]
                            && (acc_idx[grant_to[j]] == islip_pkg::ptr_t'(j));
            round.by[j]   = grant_to[j];
        end
    end

    // Pointer updates on each round handed to the emitter
    always_comb
    begin
        grant_ptr_next  = grant_ptr_reg;
        accept_ptr_next = accept_ptr_reg;
        if (load)
        begin
            for (int i = 0; i < P; i++)
            begin
                if (acc_found[i])
                begin
                    accept_ptr_next[i] = islip_pkg::wrap_inc(acc_idx[i]);
                end
            end
            for (int j = 0; j < P; j++)
            begin
                if (round.mask[j])
                begin
                    grant_ptr_next[j] = islip_pkg::wrap_inc(grant_to[j]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < P; p++)
            begin
                grant_ptr_reg[p]  <= islip_pkg::ptr_t'(p);
                accept_ptr_reg[p] <= islip_pkg::ptr_t'(p);
            end
        end
        else
        begin
            grant_ptr_reg  <= grant_ptr_next;
            accept_ptr_reg <= accept_ptr_next;
        end
    end

    // Output stage
    islip_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .round_in (round),
        .free     (emit_free),
        .pairs    (pairs)
    );

endmodule

>>> bench/islip_crossbar_scheduler_tb.sv
// Self-checking bench for the single-iteration iSLIP crossbar scheduler.
module islip_crossbar_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One result word as it leaves the match channel
    typedef struct packed {
        logic                   match_valid;
        islip_pkg::port_field_t matched_input;
        islip_pkg::port_field_t matched_output;
        logic                   last_match;
    } match_word_t;

    // Directed row: request word, plus a hand-written result when the round is trivial
    typedef struct {
        logic [islip_pkg::REQ_W-1:0] req;
        bit                          typed;
        match_word_t                 want;
    } stim_row_t;

    // Shapes of random request words
    typedef enum int {
        SHAPE_FULL,
        SHAPE_SPARSE,
        SHAPE_PERM,
        SHAPE_DENSE,
        SHAPE_HOTSPOT,
        SHAPE_SINGLE
    } req_shape_t;

    localparam int          N_DIRECTED  = 20;
    localparam int          N_RANDOM    = 400;
    localparam int          STALL_LIMIT = 2000;
    localparam int          DRAIN_WAIT  = 2 * islip_pkg::PORTS;
    localparam match_word_t EMPTY_ROUND = '{1'b0, 3'd0, 3'd0, 1'b1};
    localparam match_word_t NO_WANT     = '0;

    logic clk = 1'b0;
    logic rst_n;

    islip_req_if   request_ch ();
    islip_match_if pairs_ch ();

    islip_crossbar_scheduler dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .pairs   (pairs_ch)
    );

    always #1 clk = ~clk;

    // Scheduler state mirrored by the predictor
    islip_pkg::ptr_t grant_ptr  [islip_pkg::PORTS];
    islip_pkg::ptr_t accept_ptr [islip_pkg::PORTS];

    match_word_t round_words[$];
    match_word_t pending_matches[$];

    bit steady;
    int mismatches;
    int rounds_sent;
    int words_checked = 0;
    int empty_rounds;
    int full_rounds;
    int idle_cycles = 0;

    match_word_t seen_word;
    match_word_t oldest;

    // Single-line mismatch report, counted
    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic compare_field(input string field, input logic [2:0] got,
                                 input logic [2:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
        end
    endtask

    // One iSLIP iteration: grant, accept, pointer update; fills round_words
    function automatic void islip_round(input logic [islip_pkg::REQ_W-1:0] req);
        logic [islip_pkg::PORTS-1:0] granted;
        islip_pkg::ptr_t             grant_to [islip_pkg::PORTS];
        logic [islip_pkg::PORTS-1:0] taken;
        islip_pkg::ptr_t             taken_by [islip_pkg::PORTS];
        bit                          found;
        int                          i;
        int                          j;
        int                          k;
        int                          cand;
        int                          start;
        match_word_t                 w;

        round_words.delete();
        granted = '0;
        taken   = '0;

        // Grant: each output picks the first requester from its grant pointer
        for (j = 0; j < islip_pkg::PORTS; j++)
        begin
            grant_to[j] = '0;
            taken_by[j] = '0;
            for (k = 0; k < islip_pkg::PORTS; k++)
            begin
                cand = (int'(grant_ptr[j]) + k) % islip_pkg::PORTS;
                if (!granted[j] && req[cand * islip_pkg::PORTS + j])
                begin
                    granted[j]  = 1'b1;
                    grant_to[j] = islip_pkg::ptr_t'(cand);
                end
            end
        end

        // Accept: each input takes the first granting output from its accept pointer
        for (i = 0; i < islip_pkg::PORTS; i++)
        begin
            found = 1'b0;
            start = int'(accept_ptr[i]);
            for (k = 0; k < islip_pkg::PORTS; k++)
            begin
                cand = (start + k) % islip_pkg::PORTS;
                if (!found && granted[cand] && grant_to[cand] == islip_pkg::ptr_t'(i))
                begin
                    found          = 1'b1;
                    taken[cand]    = 1'b1;
                    taken_by[cand] = islip_pkg::ptr_t'(i);
                    accept_ptr[i]  = islip_pkg::ptr_t'((cand + 1) % islip_pkg::PORTS);
                end
            end
        end

        // Grant pointers move one past the accepted input; words in output order
        for (j = 0; j < islip_pkg::PORTS; j++)
        begin
            if (taken[j])
            begin
                grant_ptr[j] = islip_pkg::ptr_t'((int'(taken_by[j]) + 1) % islip_pkg::PORTS);
                w = '{1'b1, islip_pkg::port_field_t'(taken_by[j]),
                      islip_pkg::port_field_t'(j), 1'b0};
                round_words.push_back(w);
            end
        end

        if (round_words.size() == 0)
        begin
            round_words.push_back(EMPTY_ROUND);
        end
        else
        begin
            round_words[round_words.size() - 1].last_match = 1'b1;
        end
    endfunction

    // Random request word of a drawn shape
    function automatic logic [islip_pkg::REQ_W-1:0] random_request();
        logic [islip_pkg::REQ_W-1:0] r;
        req_shape_t                  shape;
        int                          pick;
        int                          b;
        int                          o;

        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            shape = SHAPE_FULL;
        end
        else if (pick < 55)
        begin
            shape = SHAPE_SPARSE;
        end
        else if (pick < 75)
        begin
            shape = SHAPE_PERM;
        end
        else if (pick < 87)
        begin
            shape = SHAPE_DENSE;
        end
        else if (pick < 94)
        begin
            shape = SHAPE_HOTSPOT;
        end
        else
        begin
            shape = SHAPE_SINGLE;
        end

        r = '0;
        case (shape)
            SHAPE_FULL:
            begin
                r = {$urandom, $urandom};
            end
            SHAPE_SPARSE:
            begin
                for (b = 0; b < islip_pkg::REQ_W; b++)
                begin
                    r[b] = ($urandom_range(0, 7) == 0);
                end
            end
            SHAPE_PERM:
            begin
                // mostly one output per input, so many rounds match several ports
                for (b = 0; b < islip_pkg::PORTS; b++)
                begin
                    if ($urandom_range(0, 3) != 0)
                    begin
                        r[b * islip_pkg::PORTS + $urandom_range(0, islip_pkg::PORTS - 1)] = 1'b1;
                    end
                end
            end
            SHAPE_DENSE:
            begin
                r = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
            end
            SHAPE_HOTSPOT:
            begin
                o = $urandom_range(0, islip_pkg::PORTS - 1);
                for (b = 0; b < islip_pkg::PORTS; b++)
                begin
                    r[b * islip_pkg::PORTS + o] = ($urandom_range(0, 1) == 1);
                end
            end
            default:
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    r[$urandom_range(0, islip_pkg::REQ_W - 1)] = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // Offer one request word after a random gap; predict on acceptance
    task automatic send_round(input logic [islip_pkg::REQ_W-1:0] req, input bit typed,
                              input match_word_t want);
        int gap;

        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_ch.valid          <= 1'b1;
        request_ch.request_matrix <= req;
        do
            @(posedge clk);
        while (!request_ch.ready);

        islip_round(req);
        rounds_sent++;
        if (!round_words[0].match_valid)
        begin
            empty_rounds++;
        end
        if (round_words.size() == islip_pkg::PORTS)
        begin
            full_rounds++;
        end
        if (typed)
        begin
            pending_matches.push_back(want);
        end
        else
        begin
            foreach (round_words[n])
            begin
                pending_matches.push_back(round_words[n]);
            end
        end
    endtask

    // Hold the sender until every expected word has come back
    task automatic drain_matches();
        request_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_matches.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Directed rounds; single-request rounds and empty rounds are written out by hand
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{64'h0000_0000_0000_0000, 1'b1, EMPTY_ROUND},
        '{64'h0000_0000_0000_0001, 1'b1, '{1'b1, 3'd0, 3'd0, 1'b1}},
        '{64'h8000_0000_0000_0000, 1'b1, '{1'b1, 3'd7, 3'd7, 1'b1}},
        '{64'h0000_0000_0000_0080, 1'b1, '{1'b1, 3'd0, 3'd7, 1'b1}},
        '{64'h0100_0000_0000_0000, 1'b1, '{1'b1, 3'd7, 3'd0, 1'b1}},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_WANT},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_WANT},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_WANT},
        '{64'h8040_2010_0804_0201, 1'b0, NO_WANT},
        '{64'h0102_0408_1020_4080, 1'b0, NO_WANT},
        '{64'h0101_0101_0101_0101, 1'b0, NO_WANT},
        '{64'h0101_0101_0101_0101, 1'b0, NO_WANT},
        '{64'h0000_0000_0000_00FF, 1'b0, NO_WANT},
        '{64'hFF00_0000_0000_0000, 1'b0, NO_WANT},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_WANT},
        '{64'h5555_5555_5555_5555, 1'b0, NO_WANT},
        '{64'h0000_0000_0000_0000, 1'b1, EMPTY_ROUND},
        '{64'h8080_8080_8080_8080, 1'b0, NO_WANT},
        '{64'hFFFF_FFFF_0000_0000, 1'b0, NO_WANT},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_WANT}
    };

    // Stimulus and end of run
    initial
    begin
        rst_n                     <= 1'b0;
        request_ch.valid          <= 1'b0;
        request_ch.request_matrix <= '0;
        steady      = 1'b0;
        mismatches  = 0;
        rounds_sent = 0;
        empty_rounds = 0;
        full_rounds = 0;
        for (int p = 0; p < islip_pkg::PORTS; p++)
        begin
            grant_ptr[p]  = islip_pkg::ptr_t'(p);
            accept_ptr[p] = islip_pkg::ptr_t'(p);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < N_DIRECTED; n++)
        begin
            send_round(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].want);
        end
        drain_matches();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // every fourth block of 50 rounds runs with no gaps on either side
            steady = ((n / 50) % 4 == 2);
            if (n == N_RANDOM / 2)
            begin
                drain_matches();
            end
            send_round(random_request(), 1'b0, NO_WANT);
        end

        drain_matches();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Ran %0d rounds (%0d directed), checked %0d match words.",
                 rounds_sent, N_DIRECTED, words_checked);
        $display("Rounds with no match: %0d, rounds matching all %0d ports: %0d.",
                 empty_rounds, islip_pkg::PORTS, full_rounds);
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Receiver: random stall before each word, with steady stretches
    initial
    begin
        pairs_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            int stall;
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                pairs_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pairs_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!pairs_ch.valid);
        end
    end

    // Check every accepted match word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pairs_ch.valid && pairs_ch.ready)
        begin
            seen_word = '{pairs_ch.match_valid, pairs_ch.matched_input,
                          pairs_ch.matched_output, pairs_ch.last_match};
            words_checked++;
            if (pending_matches.size() == 0)
            begin
                report_mismatch($sformatf("match word %p with nothing expected", seen_word));
            end
            else
            begin
                oldest = pending_matches.pop_front();
                compare_field("match_valid", 3'(seen_word.match_valid),
                              3'(oldest.match_valid));
                compare_field("matched_input", seen_word.matched_input,
                              oldest.matched_input);
                compare_field("matched_output", seen_word.matched_output,
                              oldest.matched_output);
                compare_field("last_match", 3'(seen_word.last_match),
                              3'(oldest.last_match));
            end
        end
    end

    // Watchdog: too long with no word moving on either channel
    always @(posedge clk)
    begin
        if ((request_ch.valid && request_ch.ready) || (pairs_ch.valid && pairs_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles, %0d still expected",
                     idle_cycles, pending_matches.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
